// ===== rtl/core/btpc_pkg.sv =====
package btpc_pkg;

    // stage plan of the compensation pipeline
    localparam int DIV_STEPS = 32;
    localparam int ST_IN     = 0;                       // ut - ac6 times ac5
    localparam int ST_TSET   = 1;                       // x1, divisor, magnitudes
    localparam int ST_TDIV   = 2;                       // first temperature divide step
    localparam int ST_B5     = ST_TDIV + DIV_STEPS;     // quotient sign, b5, b6
    localparam int ST_MUL1   = ST_B5 + 1;               // b6*b6, ac2*b6, ac3*b6
    localparam int ST_MUL2   = ST_B5 + 2;               // sq, b2*sq, b1*sq
    localparam int ST_SUMS   = ST_B5 + 3;               // x3 terms, b3 numerator
    localparam int ST_B3     = ST_B5 + 4;               // b3, ac4 product
    localparam int ST_B7     = ST_B5 + 5;               // b4, b7 product
    localparam int ST_PSET   = ST_B5 + 6;               // quotient branch select
    localparam int ST_PDIV   = ST_PSET + 1;             // first pressure divide step
    localparam int ST_PFIX   = ST_PDIV + DIV_STEPS;     // p, t*t, -7357*p
    localparam int ST_PMUL   = ST_PFIX + 1;             // t*t*3038
    localparam int ST_OUT    = ST_PFIX + 2;             // final sums, output register
    localparam int NUM_STG   = ST_OUT + 1;

    localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [2:0] CFG_B1_B2   = 3'd3;
    localparam logic [2:0] CFG_MC_MD   = 3'd4;
    localparam logic [2:0] CFG_OSS     = 3'd5;

    typedef struct packed {
        logic        err;
        logic        neg;
        logic        dbl;
        logic [31:0] up;
        logic [31:0] x1t;
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic [31:0] b5;
        logic [31:0] b6;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mc;
        logic [31:0] x3a;
        logic [31:0] x3b;
        logic [31:0] b3n;
        logic [31:0] b3;
        logic [31:0] b4;
        logic [31:0] p;
        logic [31:0] tout;
    } t_item;

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // one restoring step: quotient bits enter at the bottom of quo
    function automatic t_item div_step(input t_item s);
        logic [32:0] r;
        logic [32:0] d;
        r = {s.rem, s.quo[31]};
        d = r - {1'b0, s.dvs};
        div_step = s;
        if (!d[32]) begin
            div_step.rem = d[31:0];
            div_step.quo = {s.quo[30:0], 1'b1};
        end else begin
            div_step.rem = r[31:0];
            div_step.quo = {s.quo[30:0], 1'b0};
        end
    endfunction

endpackage

// ===== rtl/core/baro_temp_pressure_compensation.sv =====
// barometer compensation pipeline: takes one transaction of raw temperature (16 bits) and
// raw pressure (24 bits) per cycle and gives temperature in tenths of a degree and pressure
// in pascals with the sensor's integer scheme and 32-bit wraparound. throughput is one
// transaction per cycle; the two 32-bit divisions are unrolled into one restoring step per
// stage, which sets most of the pipeline depth. a zero divisor raises
// divide_error and zeroes both results. the whole pipe holds while the output is stalled.
// calibration and oversampling registers are read live, so write them only while idle.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // temperature_tenths[31:0], pressure_pa[63:32],
                                   // divide_error[64], zero fill [71:65]
);

    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_wdata;
                CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_wdata;
                CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_wdata;
                CFG_B1_B2:   r_b1_b2   <= i_cfg_wdata;
                CFG_MC_MD:   r_mc_md   <= i_cfg_wdata;
                CFG_OSS:     r_oss     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // coefficients widened to 32 bits
    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = sx16(r_ac1_ac2[31:16]);
    assign w_ac2 = sx16(r_ac1_ac2[15:0]);
    assign w_ac3 = sx16(r_ac3_ac4[31:16]);
    assign w_ac4 = {16'd0, r_ac3_ac4[15:0]};
    assign w_ac5 = {16'd0, r_ac5_ac6[31:16]};
    assign w_ac6 = {16'd0, r_ac5_ac6[15:0]};
    assign w_b1  = sx16(r_b1_b2[31:16]);
    assign w_b2  = sx16(r_b1_b2[15:0]);
    assign w_mc  = sx16(r_mc_md[31:16]);
    assign w_md  = sx16(r_mc_md[15:0]);

    t_item r_pipe [NUM_STG];
    t_item n_pipe [NUM_STG];
    logic [NUM_STG-1:0] r_vld;
    logic w_en;

    // whole pipe advances unless the output register holds an untaken result
    assign w_en     = !r_vld[NUM_STG-1] || m_tready;
    assign s_tready = w_en;

    // ut - ac6 times ac5, pressure alignment
    always_comb begin
        logic [31:0] ut;
        ut = {16'd0, s_tdata[15:0]};
        n_pipe[ST_IN]    = '0;
        n_pipe[ST_IN].up = {8'd0, s_tdata[39:16] >> (4'd8 - {2'd0, r_oss})};
        n_pipe[ST_IN].mb = (ut - w_ac6) * w_ac5;
    end

    // x1, divisor, magnitudes for the signed temperature quotient
    always_comb begin
        logic [31:0] x1, dv, num;
        x1  = asr(r_pipe[ST_IN].mb, 5'd15);
        dv  = x1 + w_md;
        num = {w_mc[20:0], 11'd0};
        n_pipe[ST_TSET]     = r_pipe[ST_IN];
        n_pipe[ST_TSET].x1t = x1;
        n_pipe[ST_TSET].err = (dv == 32'd0);
        n_pipe[ST_TSET].neg = num[31] ^ dv[31];
        n_pipe[ST_TSET].quo = num[31] ? 32'd0 - num : num;
        n_pipe[ST_TSET].dvs = dv[31] ? 32'd0 - dv : dv;
        n_pipe[ST_TSET].rem = '0;
    end

    for (genvar k = ST_TDIV; k < ST_B5; k++) begin : g_tdiv
        always_comb n_pipe[k] = div_step(r_pipe[k-1]);
    end

    // signed quotient, b5, b6
    always_comb begin
        logic [31:0] x2, b5;
        x2 = r_pipe[ST_B5-1].neg ? 32'd0 - r_pipe[ST_B5-1].quo : r_pipe[ST_B5-1].quo;
        b5 = r_pipe[ST_B5-1].x1t + x2;
        n_pipe[ST_B5]    = r_pipe[ST_B5-1];
        n_pipe[ST_B5].b5 = b5;
        n_pipe[ST_B5].b6 = b5 - 32'd4000;
    end

    always_comb begin
        n_pipe[ST_MUL1]    = r_pipe[ST_B5];
        n_pipe[ST_MUL1].ma = r_pipe[ST_B5].b6 * r_pipe[ST_B5].b6;
        n_pipe[ST_MUL1].mb = w_ac2 * r_pipe[ST_B5].b6;
        n_pipe[ST_MUL1].mc = w_ac3 * r_pipe[ST_B5].b6;
    end

    // ma becomes b2*sq, x3a temporarily carries b1*sq
    always_comb begin
        logic [31:0] sq;
        sq = asr(r_pipe[ST_MUL1].ma, 5'd12);
        n_pipe[ST_MUL2]     = r_pipe[ST_MUL1];
        n_pipe[ST_MUL2].ma  = w_b2 * sq;
        n_pipe[ST_MUL2].x3a = w_b1 * sq;
    end

    always_comb begin
        logic [31:0] x3;
        x3 = asr(r_pipe[ST_MUL2].ma, 5'd11) + asr(r_pipe[ST_MUL2].mb, 5'd11);
        n_pipe[ST_SUMS]     = r_pipe[ST_MUL2];
        n_pipe[ST_SUMS].x3a = x3;
        n_pipe[ST_SUMS].b3n = (({w_ac1[29:0], 2'd0} + x3) << r_oss) + 32'd2;
        n_pipe[ST_SUMS].x3b = asr(asr(r_pipe[ST_MUL2].mc, 5'd13)
                                  + asr(r_pipe[ST_MUL2].x3a, 5'd16) + 32'd2, 5'd2);
    end

    // b3 is a signed divide by four truncating toward zero; ma carries the ac4 product
    always_comb begin
        logic [31:0] n3;
        n3 = r_pipe[ST_SUMS].b3n;
        n_pipe[ST_B3]    = r_pipe[ST_SUMS];
        n_pipe[ST_B3].b3 = n3[31] ? asr(n3 + 32'd3, 5'd2) : asr(n3, 5'd2);
        n_pipe[ST_B3].ma = w_ac4 * (r_pipe[ST_SUMS].x3b + 32'd32768);
    end

    always_comb begin
        logic [31:0] b4;
        b4 = r_pipe[ST_B3].ma >> 15;
        n_pipe[ST_B7]     = r_pipe[ST_B3];
        n_pipe[ST_B7].b4  = b4;
        n_pipe[ST_B7].err = r_pipe[ST_B3].err || (b4 == 32'd0);
        n_pipe[ST_B7].mb  = (r_pipe[ST_B3].up - r_pipe[ST_B3].b3) * (32'd50000 >> r_oss);
    end

    // pick doubling before or after the unsigned division
    always_comb begin
        logic [31:0] b7;
        b7 = r_pipe[ST_B7].mb;
        n_pipe[ST_PSET]     = r_pipe[ST_B7];
        n_pipe[ST_PSET].dbl = b7[31];
        n_pipe[ST_PSET].quo = b7[31] ? b7 : {b7[30:0], 1'b0};
        n_pipe[ST_PSET].dvs = r_pipe[ST_B7].b4;
        n_pipe[ST_PSET].rem = '0;
    end

    for (genvar k = ST_PDIV; k < ST_PFIX; k++) begin : g_pdiv
        always_comb n_pipe[k] = div_step(r_pipe[k-1]);
    end

    always_comb begin
        logic [31:0] p, t;
        p = r_pipe[ST_PFIX-1].dbl ? {r_pipe[ST_PFIX-1].quo[30:0], 1'b0}
                                  : r_pipe[ST_PFIX-1].quo;
        t = asr(p, 5'd8);
        n_pipe[ST_PFIX]    = r_pipe[ST_PFIX-1];
        n_pipe[ST_PFIX].p  = p;
        n_pipe[ST_PFIX].ma = t * t;
        n_pipe[ST_PFIX].mb = (32'd0 - 32'd7357) * p;
    end

    always_comb begin
        n_pipe[ST_PMUL]    = r_pipe[ST_PFIX];
        n_pipe[ST_PMUL].ma = r_pipe[ST_PFIX].ma * 32'd3038;
    end

    // final correction, temperature rounding, error forcing
    always_comb begin
        logic [31:0] p;
        p = r_pipe[ST_PMUL].p + asr(asr(r_pipe[ST_PMUL].ma, 5'd16)
                                    + asr(r_pipe[ST_PMUL].mb, 5'd16) + 32'd3791, 5'd4);
        n_pipe[ST_OUT] = r_pipe[ST_PMUL];
        if (r_pipe[ST_PMUL].err) begin
            n_pipe[ST_OUT].p    = '0;
            n_pipe[ST_OUT].tout = '0;
        end else begin
            n_pipe[ST_OUT].p    = p;
            n_pipe[ST_OUT].tout = asr(r_pipe[ST_PMUL].b5 + 32'd8, 5'd4);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STG-2:0], s_tvalid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign m_tvalid = r_vld[NUM_STG-1];
    assign m_tdata  = {7'd0, r_pipe[NUM_STG-1].err, r_pipe[NUM_STG-1].p,
                       r_pipe[NUM_STG-1].tout};

endmodule

// ===== rtl/core/btpc_checker.sv =====
module btpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // input side never blocked while the output register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    // an error result carries zeros in both data fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == 64'd0))
        else $error("error result with nonzero data");

    // stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled transaction changed");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
